/* src/key_debounce_autorepeat_assert.svh */
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_assert
// assertion macros shared by the key debounce block
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

`ifndef ASSERT_OFF

`define KDAR_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition");

`define KDAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

`define KDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle implication");

`else

`define KDAR_ASSERT_NEVER(label, clk, rst_n, cond)
`define KDAR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define KDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/kdar_pkg.sv */
// ----------------------------------------------------------------------------
// kdar_pkg
// types and constants of the key debounce and auto-repeat block
// ----------------------------------------------------------------------------
package kdar_pkg;

	localparam int KEY_SLOTS   = 16;
	localparam int KEY_IDX_W   = 4;
	localparam int LIMIT_W     = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT   = CFG_IDX_W'(1);

	localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET = 8'd4;
	localparam logic [LIMIT_W-1:0] REPEAT_RESET   = 8'd100;

	typedef enum logic [1:0] {
		KIND_DOWN   = 2'd0,
		KIND_UP     = 2'd1,
		KIND_REPEAT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KEY_SLOTS-1:0]  mask;
		kind_t [KEY_SLOTS-1:0] kinds;
	} tick_rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

/* src/kdar_front.sv */
// ----------------------------------------------------------------------------
// kdar_front
// per-key hold counters and pressed flags; classifies each tick into events
// ----------------------------------------------------------------------------
module kdar_front #(
	parameter int NUM_KEYS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [kdar_pkg::KEY_SLOTS-1:0]   key_levels,
	input  logic                             cfg_write,
	input  logic [kdar_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kdar_pkg::LIMIT_W-1:0]     cfg_data,
	output kdar_pkg::tick_rec_t              rec,
	output logic                             has_event
);
	import kdar_pkg::*;

	localparam int SCAN = (NUM_KEYS > KEY_SLOTS) ? KEY_SLOTS : NUM_KEYS;

	logic [LIMIT_W-1:0]    debounce_q;
	logic [LIMIT_W-1:0]    repeat_q;
	logic [KEY_SLOTS-1:0]  ev_mask;
	kind_t [KEY_SLOTS-1:0] ev_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			repeat_q   <= REPEAT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEBOUNCE_LIMIT: debounce_q <= cfg_data;
				REG_REPEAT_LIMIT:   repeat_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_key
		if (i < SCAN) begin : g_live
			logic [LIMIT_W-1:0] hold_q;
			logic               pressed_q;
			logic               low;
			logic [LIMIT_W-1:0] inc;
			logic               hit;

			assign low = ~key_levels[i];
			assign inc = hold_q + LIMIT_W'(1);
			assign hit = pressed_q ? (inc > repeat_q) : (inc > debounce_q);
			assign ev_mask[i] = low ? hit : pressed_q;
			assign ev_kind[i] = !low ? KIND_UP : (pressed_q ? KIND_REPEAT : KIND_DOWN);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hold_q    <= '0;
					pressed_q <= 1'b0;
				end else if (accept) begin
					hold_q <= (low && !hit) ? inc : '0;
					if (!low)
						pressed_q <= 1'b0;
					else if (hit)
						pressed_q <= 1'b1;
				end
			end
		end else begin : g_idle
			assign ev_mask[i] = 1'b0;
			assign ev_kind[i] = KIND_DOWN;
		end
	end

	assign rec.mask  = ev_mask;
	assign rec.kinds = ev_kind;
	assign has_event = |ev_mask;

endmodule

/* src/kdar_fifo.sv */
// ----------------------------------------------------------------------------
// kdar_fifo
// short queue of tick records between classification and event output
// ----------------------------------------------------------------------------
`include "key_debounce_autorepeat_assert.svh"

module kdar_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  kdar_pkg::tick_rec_t     wr_data,
	input  logic                    pop,
	output kdar_pkg::tick_rec_t     rd_data,
	output kdar_pkg::queue_status_t status
);
	import kdar_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tick_rec_t        mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_data      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	`KDAR_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && status.full)
	`KDAR_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && status.empty)
	`KDAR_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(QUEUE_DEPTH))

endmodule

/* src/kdar_back.sv */
// ----------------------------------------------------------------------------
// kdar_back
// walks the head tick record in key order, one event per cycle while out_stall is low
// ----------------------------------------------------------------------------
`include "key_debounce_autorepeat_assert.svh"

module kdar_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kdar_pkg::tick_rec_t            head,
	input  kdar_pkg::queue_status_t        status,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     event_kind,
	output logic [kdar_pkg::KEY_IDX_W-1:0] key_index,
	output logic                           last_event
);
	import kdar_pkg::*;

	logic [KEY_SLOTS-1:0] sent_q;
	logic                 out_valid_q;
	kind_t                kind_q;
	logic [KEY_IDX_W-1:0] idx_q;
	logic                 last_q;
	logic [KEY_SLOTS-1:0] avail;
	logic [KEY_SLOTS-1:0] pick;
	logic [KEY_SLOTS-1:0] rest;
	logic [KEY_IDX_W-1:0] idx;
	logic                 is_last;
	logic                 advance;
	logic                 load;

	function automatic logic [KEY_IDX_W-1:0] lowest(input logic [KEY_SLOTS-1:0] v);
		logic [KEY_IDX_W-1:0] r;
		r = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--)
			if (v[i])
				r = KEY_IDX_W'(i);
		return r;
	endfunction

	assign avail   = head.mask & ~sent_q;
	assign idx     = lowest(avail);
	assign pick    = KEY_SLOTS'(1) << idx;
	assign rest    = avail & ~pick;
	assign is_last = (rest == '0);
	assign advance = !out_valid_q || !out_stall;
	assign load    = advance && !status.empty;
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q      <= '0;
		end else begin
			if (advance)
				out_valid_q <= !status.empty;
			if (load)
				sent_q <= is_last ? '0 : (sent_q | pick);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= head.kinds[idx];
			idx_q  <= idx;
			last_q <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign key_index  = idx_q;
	assign last_event = last_q;

	`KDAR_ASSERT_IMPLIES(a_sent_in_head, clk, arst_n, !status.empty, (sent_q & ~head.mask) == '0)
	`KDAR_ASSERT_IMPLIES(a_sent_clear_empty, clk, arst_n, status.empty, sent_q == '0)
	`KDAR_ASSERT_NEXT(a_stall_holds_walk, clk, arst_n, out_valid_q && out_stall, $stable(sent_q))

endmodule

/* src/key_debounce_autorepeat.sv */
// ----------------------------------------------------------------------------
// key_debounce_autorepeat
// debounce and auto-repeat for a bank of active-low keys
//
//   channel  direction  handshake             payload
//   tick     in         in_valid / in_stall   key_levels
//   event    out        out_valid / out_stall event_kind, key_index, last_event
//   config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// a tick is taken whenever the two-entry record queue has room
// events leave one per cycle while out_stall is low, lowest key index first
// a quiet tick leaves no record in the queue
// reset clears all counters and flags and loads limits 4 and 100
// in_stall is high only while the queue is full; cfg_ready is always high
// ----------------------------------------------------------------------------
module key_debounce_autorepeat #(
	parameter int NUM_KEYS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [kdar_pkg::KEY_SLOTS-1:0] key_levels,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     event_kind,
	output logic [kdar_pkg::KEY_IDX_W-1:0] key_index,
	output logic                           last_event,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kdar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kdar_pkg::LIMIT_W-1:0]   cfg_data
);
	import kdar_pkg::*;

	logic          accept;
	logic          has_event;
	logic          pop;
	tick_rec_t     rec;
	tick_rec_t     head;
	queue_status_t status;

	assign cfg_ready = 1'b1;
	assign in_stall  = status.full;
	assign accept    = in_valid && !status.full;

	kdar_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.key_levels(key_levels),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rec       (rec),
		.has_event (has_event)
	);

	kdar_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && has_event),
		.wr_data(rec),
		.pop    (pop),
		.rd_data(head),
		.status (status)
	);

	kdar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_kind(event_kind),
		.key_index (key_index),
		.last_event(last_event)
	);

endmodule
